>>> rtl/ngp_pkg.sv
// Shared constants, types and helper functions of the NMEA GGA position parser.
package ngp_pkg;

    // Number format of the position fields.
    localparam int unsigned FRACTION_DIGITS = 4;
    localparam int unsigned INTEGER_DIGITS  = 5;

    function automatic longint unsigned pow10_const(input int unsigned n);
        longint unsigned v;
        v = 1;
        for (int unsigned i = 0; i < n; i++) begin
            v = v * 10;
        end
        return v;
    endfunction

    // Accumulators hold the field value in units of 10^-FRACTION_DIGITS.
    localparam longint unsigned SCALE     = pow10_const(FRACTION_DIGITS);
    localparam longint unsigned ACC_LIMIT = (pow10_const(INTEGER_DIGITS) - 1) * SCALE;
    localparam longint unsigned ACC_MAX   = pow10_const(INTEGER_DIGITS) * SCALE - 1;
    localparam int unsigned     ACC_W     = $clog2(ACC_MAX + 1);
    localparam int unsigned     ACCX_W    = ACC_W + 4;

    // Result format.
    localparam int unsigned     OUT_W = 35;
    localparam longint unsigned UNIT  = 10_000_000;

    // Degree split: deg = value / DEG_DIV, done as a reciprocal multiply plus one correction.
    localparam longint unsigned DEG_DIV     = 100 * SCALE;
    localparam longint unsigned DEG_MAX     = ACC_MAX / DEG_DIV;
    localparam int unsigned     DEG_W       = $clog2(DEG_MAX + 2);
    localparam int unsigned     MIN_W       = $clog2(DEG_DIV);
    localparam longint unsigned DEG_RECIP   = (64'd1 << ACC_W) / DEG_DIV;
    localparam int unsigned     DEG_RECIP_W = $clog2(DEG_RECIP + 1);
    localparam int unsigned     P1_W        = ACC_W + DEG_RECIP_W;
    localparam int unsigned     DG_W        = $clog2(DEG_MAX * UNIT + 1);

    // Minutes to 1e-7 degree: minutes * UNIT / (60 * SCALE), reduced by the common factor.
    localparam int unsigned     GCD_P2 = (FRACTION_DIGITS + 2 < 7) ? FRACTION_DIGITS + 2 : 7;
    localparam int unsigned     GCD_P5 = (FRACTION_DIGITS + 1 < 7) ? FRACTION_DIGITS + 1 : 7;
    localparam longint unsigned FR_GCD = (64'd1 << GCD_P2) * pow10_const(0) *
                                         (pow10_const(GCD_P5) >> GCD_P5);
    localparam longint unsigned FR_NUM      = UNIT / FR_GCD;
    localparam longint unsigned FR_DEN      = (60 * SCALE) / FR_GCD;
    localparam longint unsigned MN_MAX      = (DEG_DIV - 1) * FR_NUM;
    localparam int unsigned     MN_W        = $clog2(MN_MAX + 1);
    localparam longint unsigned FR_RECIP    = (64'd1 << MN_W) / FR_DEN;
    localparam int unsigned     FR_RECIP_W  = $clog2(FR_RECIP + 1);
    localparam int unsigned     P4_W        = MN_W + FR_RECIP_W;
    localparam int unsigned     FR_W        = $clog2(MN_MAX / FR_DEN + 2);
    localparam int unsigned     DEN_W       = $clog2(FR_DEN + 1);

    // Characters of interest.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SOUTH   = 8'h53;
    localparam logic [7:0] CH_WEST    = 8'h57;

    // Field positions and limits of the sentence walker.
    localparam logic [3:0] FLD_HEADER   = 4'd0;
    localparam logic [3:0] FLD_LAT      = 4'd2;
    localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
    localparam logic [3:0] FLD_LON      = 4'd4;
    localparam logic [3:0] FLD_LON_HEMI = 4'd5;
    localparam logic [3:0] MIN_FIELDS   = 4'd10;
    localparam logic [3:0] FIELD_SAT    = 4'd15;
    localparam logic [2:0] CHAR_SAT     = 3'd7;
    localparam logic [2:0] HDR_LEN      = 3'd6;
    localparam logic [2:0] NUM_ENDED    = 3'd7;

    // Queue between the parser and the converter.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Converter pipeline depth, output register included.
    localparam int unsigned PIPE_STAGES = 6;

    typedef struct packed {
        logic [ACC_W-1:0] lat_acc;
        logic             south;
        logic [ACC_W-1:0] lon_acc;
        logic             west;
    } fix_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Expected character of the sentence header at a position.
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Weight of the fraction digit at a position: 10^(FRACTION_DIGITS - pos).
    function automatic logic [ACC_W-1:0] frac_weight(input logic [2:0] pos);
        logic [ACC_W-1:0] w;
        w = ACC_W'(1);
        for (int i = 0; i < int'(FRACTION_DIGITS); i++) begin
            if (int'(pos) + i < int'(FRACTION_DIGITS)) begin
                w = w * ACC_W'(10);
            end
        end
        return w;
    endfunction

endpackage

>>> rtl/ngp_parser.sv
// Byte-level sentence walker that builds the raw position fields of a GGA sentence.
module ngp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output ngp_pkg::fix_entry_t push_entry
);

    logic [3:0]                field_idx_reg, field_idx_next;
    logic [2:0]                char_cnt_reg, char_cnt_next;
    logic                      hdr_ok_reg, hdr_ok_next;
    logic [ngp_pkg::ACC_W-1:0] lat_acc_reg, lat_acc_next;
    logic [ngp_pkg::ACC_W-1:0] lon_acc_reg, lon_acc_next;
    logic                      in_frac_reg, in_frac_next;
    logic [2:0]                frac_cnt_reg, frac_cnt_next;
    logic                      south_reg, south_next;
    logic                      west_reg, west_next;

    logic                       is_digit;
    logic [3:0]                 digit;
    logic [ngp_pkg::ACC_W-1:0]  acc_cur, acc_new;
    logic [ngp_pkg::ACCX_W-1:0] int_sum;
    logic [2:0]                 frac_pos;

    assign is_digit = (rx_byte >= ngp_pkg::CH_ZERO) && (rx_byte <= ngp_pkg::CH_NINE);
    assign digit    = rx_byte[3:0];
    assign acc_cur  = (field_idx_reg == ngp_pkg::FLD_LAT) ? lat_acc_reg : lon_acc_reg;
    assign frac_pos = frac_cnt_reg + 3'd1;
    assign int_sum  = ngp_pkg::ACCX_W'(acc_cur) * ngp_pkg::ACCX_W'(10)
                    + ngp_pkg::ACCX_W'(digit) * ngp_pkg::ACCX_W'(ngp_pkg::SCALE);

    assign push_entry.lat_acc = lat_acc_reg;
    assign push_entry.south   = south_reg;
    assign push_entry.lon_acc = lon_acc_reg;
    assign push_entry.west    = west_reg;

    // Number digest for the field in progress, shared by latitude and longitude.
    always_comb begin
        acc_new       = acc_cur;
        in_frac_next  = in_frac_reg;
        frac_cnt_next = frac_cnt_reg;
        if (frac_cnt_reg != ngp_pkg::NUM_ENDED) begin
            if (is_digit) begin
                if (!in_frac_reg) begin
                    if (int_sum > ngp_pkg::ACCX_W'(ngp_pkg::ACC_LIMIT)) begin
                        acc_new = ngp_pkg::ACC_W'(ngp_pkg::ACC_LIMIT);
                    end else begin
                        acc_new = int_sum[ngp_pkg::ACC_W-1:0];
                    end
                end else if (frac_cnt_reg < 3'(ngp_pkg::FRACTION_DIGITS)) begin
                    frac_cnt_next = frac_pos;
                    acc_new = acc_cur
                            + ngp_pkg::ACC_W'(digit) * ngp_pkg::frac_weight(frac_pos);
                end
            end else if (rx_byte == ngp_pkg::CH_DOT && !in_frac_reg) begin
                in_frac_next = 1'b1;
            end else begin
                in_frac_next  = 1'b1;
                frac_cnt_next = ngp_pkg::NUM_ENDED;
            end
        end
    end

    always_comb begin
        push           = 1'b0;
        field_idx_next = field_idx_reg;
        char_cnt_next  = char_cnt_reg;
        hdr_ok_next    = hdr_ok_reg;
        lat_acc_next   = lat_acc_reg;
        lon_acc_next   = lon_acc_reg;
        south_next     = south_reg;
        west_next      = west_reg;
        if (byte_accept) begin
            if (rx_byte == ngp_pkg::CH_NEWLINE) begin
                push           = hdr_ok_reg && (field_idx_reg >= ngp_pkg::MIN_FIELDS);
                field_idx_next = '0;
                char_cnt_next  = '0;
                hdr_ok_next    = 1'b1;
                lat_acc_next   = '0;
                lon_acc_next   = '0;
                south_next     = 1'b0;
                west_next      = 1'b0;
            end else if (rx_byte == ngp_pkg::CH_COMMA) begin
                if (field_idx_reg == ngp_pkg::FLD_HEADER && char_cnt_reg != ngp_pkg::HDR_LEN) begin
                    hdr_ok_next = 1'b0;
                end
                if (field_idx_reg != ngp_pkg::FIELD_SAT) begin
                    field_idx_next = field_idx_reg + 4'd1;
                end
                char_cnt_next = '0;
            end else begin
                unique case (field_idx_reg)
                    ngp_pkg::FLD_HEADER: begin
                        if (char_cnt_reg >= ngp_pkg::HDR_LEN ||
                            rx_byte != ngp_pkg::hdr_char(char_cnt_reg)) begin
                            hdr_ok_next = 1'b0;
                        end
                    end
                    ngp_pkg::FLD_LAT: begin
                        lat_acc_next = acc_new;
                    end
                    ngp_pkg::FLD_LAT_HEMI: begin
                        if (char_cnt_reg == 3'd0 && rx_byte == ngp_pkg::CH_SOUTH) begin
                            south_next = 1'b1;
                        end
                    end
                    ngp_pkg::FLD_LON: begin
                        lon_acc_next = acc_new;
                    end
                    ngp_pkg::FLD_LON_HEMI: begin
                        if (char_cnt_reg == 3'd0 && rx_byte == ngp_pkg::CH_WEST) begin
                            west_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (char_cnt_reg != ngp_pkg::CHAR_SAT) begin
                    char_cnt_next = char_cnt_reg + 3'd1;
                end
            end
        end
    end

    // Number flags only change inside a number field; commas and newlines clear them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_idx_reg <= '0;
            char_cnt_reg  <= '0;
            hdr_ok_reg    <= 1'b1;
            lat_acc_reg   <= '0;
            lon_acc_reg   <= '0;
            in_frac_reg   <= 1'b0;
            frac_cnt_reg  <= '0;
            south_reg     <= 1'b0;
            west_reg      <= 1'b0;
        end else begin
            field_idx_reg <= field_idx_next;
            char_cnt_reg  <= char_cnt_next;
            hdr_ok_reg    <= hdr_ok_next;
            lat_acc_reg   <= lat_acc_next;
            lon_acc_reg   <= lon_acc_next;
            south_reg     <= south_next;
            west_reg      <= west_next;
            if (byte_accept) begin
                if (rx_byte == ngp_pkg::CH_NEWLINE || rx_byte == ngp_pkg::CH_COMMA) begin
                    in_frac_reg  <= 1'b0;
                    frac_cnt_reg <= '0;
                end else if (field_idx_reg == ngp_pkg::FLD_LAT ||
                             field_idx_reg == ngp_pkg::FLD_LON) begin
                    in_frac_reg  <= in_frac_next;
                    frac_cnt_reg <= frac_cnt_next;
                end
            end
        end
    end

endmodule

>>> rtl/ngp_queue.sv
// Short register queue that decouples the sentence parser from the converter.
module ngp_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ngp_pkg::fix_entry_t    push_entry,
    input  logic                   pop,
    output ngp_pkg::fix_entry_t    pop_entry,
    output ngp_pkg::queue_status_t status
);

    ngp_pkg::fix_entry_t         mem_reg [ngp_pkg::QUEUE_DEPTH];
    logic [ngp_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [ngp_pkg::QCNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == ngp_pkg::QCNT_W'(ngp_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ngp_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ngp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + ngp_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + ngp_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/ngp_convert.sv
// One conversion lane: ddmm value in fixed point to signed 1e-7 degree, six register stages.
module ngp_convert (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [ngp_pkg::ACC_W-1:0]        value,
    input  logic                             negate,
    output logic signed [ngp_pkg::OUT_W-1:0] result
);

    // Stage 1: reciprocal product for the degree quotient.
    logic [ngp_pkg::P1_W-1:0]  p1_reg;
    logic [ngp_pkg::ACC_W-1:0] v1_reg;
    logic                      n1_reg;
    // Stage 2: quotient estimate and its remainder.
    logic [ngp_pkg::DEG_W-1:0] q2_reg;
    logic [ngp_pkg::MIN_W:0]   r2_reg;
    logic                      n2_reg;
    // Stage 3: scaled degrees and scaled minutes.
    logic [ngp_pkg::DG_W-1:0]  dg3_reg;
    logic [ngp_pkg::MN_W-1:0]  mn3_reg;
    logic                      n3_reg;
    // Stage 4: reciprocal product for the minutes quotient.
    logic [ngp_pkg::P4_W-1:0]  p4_reg;
    logic [ngp_pkg::MN_W-1:0]  mn4_reg;
    logic [ngp_pkg::DG_W-1:0]  dg4_reg;
    logic                      n4_reg;
    // Stage 5: minutes quotient estimate and its remainder.
    logic [ngp_pkg::FR_W-1:0]  f5_reg;
    logic [ngp_pkg::DEN_W:0]   r5_reg;
    logic [ngp_pkg::DG_W-1:0]  dg5_reg;
    logic                      n5_reg;

    logic [ngp_pkg::DEG_W-1:0] q_est, deg;
    logic [ngp_pkg::ACC_W-1:0] r_full;
    logic [ngp_pkg::MIN_W-1:0] minutes;
    logic [ngp_pkg::FR_W-1:0]  f_est;
    logic [ngp_pkg::MN_W-1:0]  r5_full;
    logic [ngp_pkg::OUT_W-1:0] mag;

    assign q_est  = ngp_pkg::DEG_W'(p1_reg >> ngp_pkg::ACC_W);
    assign r_full = v1_reg - ngp_pkg::ACC_W'(ngp_pkg::ACC_W'(q_est) *
                                             ngp_pkg::ACC_W'(ngp_pkg::DEG_DIV));

    // The reciprocal estimate is low by at most one.
    always_comb begin
        if (r2_reg >= (ngp_pkg::MIN_W + 1)'(ngp_pkg::DEG_DIV)) begin
            deg     = q2_reg + ngp_pkg::DEG_W'(1);
            minutes = ngp_pkg::MIN_W'(r2_reg - (ngp_pkg::MIN_W + 1)'(ngp_pkg::DEG_DIV));
        end else begin
            deg     = q2_reg;
            minutes = r2_reg[ngp_pkg::MIN_W-1:0];
        end
    end

    assign f_est   = ngp_pkg::FR_W'(p4_reg >> ngp_pkg::MN_W);
    assign r5_full = mn4_reg - ngp_pkg::MN_W'(ngp_pkg::MN_W'(f_est) *
                                              ngp_pkg::MN_W'(ngp_pkg::FR_DEN));
    assign mag     = ngp_pkg::OUT_W'(dg5_reg)
                   + ngp_pkg::OUT_W'(f5_reg)
                   + ngp_pkg::OUT_W'(r5_reg >= (ngp_pkg::DEN_W + 1)'(ngp_pkg::FR_DEN));

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= ngp_pkg::P1_W'(value) * ngp_pkg::P1_W'(ngp_pkg::DEG_RECIP);
            v1_reg  <= value;
            n1_reg  <= negate;
            q2_reg  <= q_est;
            r2_reg  <= r_full[ngp_pkg::MIN_W:0];
            n2_reg  <= n1_reg;
            dg3_reg <= ngp_pkg::DG_W'(deg) * ngp_pkg::DG_W'(ngp_pkg::UNIT);
            mn3_reg <= ngp_pkg::MN_W'(minutes) * ngp_pkg::MN_W'(ngp_pkg::FR_NUM);
            n3_reg  <= n2_reg;
            p4_reg  <= ngp_pkg::P4_W'(mn3_reg) * ngp_pkg::P4_W'(ngp_pkg::FR_RECIP);
            mn4_reg <= mn3_reg;
            dg4_reg <= dg3_reg;
            n4_reg  <= n3_reg;
            f5_reg  <= f_est;
            r5_reg  <= r5_full[ngp_pkg::DEN_W:0];
            dg5_reg <= dg4_reg;
            n5_reg  <= n4_reg;
            result  <= $signed(n5_reg ? (ngp_pkg::OUT_W'(0) - mag) : mag);
        end
    end

endmodule

>>> rtl/ngp_back.sv
// Converter back end: pops queued fixes and runs both coordinate lanes in lockstep.
module ngp_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ngp_pkg::fix_entry_t              q_entry,
    input  logic                             q_valid,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [ngp_pkg::OUT_W-1:0] m_latitude,
    output logic signed [ngp_pkg::OUT_W-1:0] m_longitude
);

    logic [ngp_pkg::PIPE_STAGES-1:0] valid_reg;
    logic                            advance;

    // The whole pipeline moves unless the output register holds an untaken beat.
    assign advance = !valid_reg[ngp_pkg::PIPE_STAGES-1] || m_ready;
    assign q_pop   = advance && q_valid;
    assign m_valid = valid_reg[ngp_pkg::PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[ngp_pkg::PIPE_STAGES-2:0], q_valid};
        end
    end

    ngp_convert u_lat (
        .aclk   (aclk),
        .en     (advance),
        .value  (q_entry.lat_acc),
        .negate (q_entry.south),
        .result (m_latitude)
    );

    ngp_convert u_lon (
        .aclk   (aclk),
        .en     (advance),
        .value  (q_entry.lon_acc),
        .negate (q_entry.west),
        .result (m_longitude)
    );

endmodule

>>> rtl/nmea_gga_position_parser_top.sv
// Top level of the NMEA GGA position parser: byte parser, fix queue and converter.
//
// The input channel (s_valid, s_ready, s_rx_byte) carries one received character per beat.
// Lines end at newline and fields split at commas. A line whose first field is exactly
// $GPGGA and which has at least ten commas produces one result beat on the output channel
// (m_valid, m_ready, m_latitude, m_longitude) in signed units of 1e-7 degree, negative for
// south or west. Other lines produce nothing.
// Throughput is one byte per cycle while s_ready is high: the parser digests each byte in
// the cycle it is taken. Each fix is queued and then passes the six register
// stages of the converter (two reciprocal multiplies with their corrections per lane).
// A four-entry fix queue sits between the parser and the converter. When the receiver
// stalls, the converter holds its pipeline, the queue fills, and s_ready drops only once
// the queue is full; a result beat waiting at the output never blocks new bytes before then.
// Synchronous active-low reset returns the parser to the start of a line, empties the
// queue and clears all pending results. No clearing pass is needed after reset.
module nmea_gga_position_parser_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [ngp_pkg::OUT_W-1:0] m_latitude,
    output logic signed [ngp_pkg::OUT_W-1:0] m_longitude
);

    logic                   byte_accept;
    logic                   q_push;
    logic                   q_pop;
    ngp_pkg::fix_entry_t    push_entry;
    ngp_pkg::fix_entry_t    pop_entry;
    ngp_pkg::queue_status_t q_status;

    // Bytes are refused only while the fix queue cannot take a finished sentence.
    assign s_ready     = !q_status.full;
    assign byte_accept = s_valid && s_ready;

    ngp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .push        (q_push),
        .push_entry  (push_entry)
    );

    ngp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    ngp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_entry     (pop_entry),
        .q_valid     (!q_status.empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_latitude  (m_latitude),
        .m_longitude (m_longitude)
    );

    // A finished sentence is never written into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_status.full)
        else $error("fix written into a full queue");

    // The converter only takes fixes that exist.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_status.empty)
        else $error("fix taken from an empty queue");

    // A stalled output beat freezes the converter, so nothing leaves the queue.
    assert property (@(posedge aclk) disable iff (!aresetn) (m_valid && !m_ready) |-> !q_pop)
        else $error("queue popped while the output beat is stalled");

endmodule
